### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NOW(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/gpne_pkg.sv
// ----------------------------------------------------------------------------
// gpne_pkg
// shared types, register codes and saturating helpers
// ----------------------------------------------------------------------------
package gpne_pkg;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF_SQ       = 3'd0,
		CFG_SWITCH_START_SQ = 3'd1,
		CFG_LJ_FLOOR_SQ     = 3'd2,
		CFG_COULOMB_FLOOR_SQ = 3'd3,
		CFG_CHARGE_SCALE    = 3'd4,
		CFG_EPSILON_SCALE   = 3'd5,
		CFG_SIGMA_SCALE     = 3'd6
	} cfg_idx_t;

	localparam logic [31:0] RST_CUTOFF_SQ        = 32'd4734976;
	localparam logic [31:0] RST_SWITCH_START_SQ  = 32'd4194304;
	localparam logic [31:0] RST_LJ_FLOOR_SQ      = 32'd2621;
	localparam logic [31:0] RST_COULOMB_FLOOR_SQ = 32'd16384;
	localparam logic [31:0] RST_CHARGE_SCALE     = 32'd65536;
	localparam logic [31:0] RST_EPSILON_SCALE    = 32'd65536;
	localparam logic [31:0] RST_SIGMA_SCALE      = 32'd65536;

	typedef enum logic [1:0] {SH_0, SH_16, SH_24, SH_32} shift_t;

	typedef struct packed {
		logic   start;
		shift_t sh;
	} mul_ctl_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} ds_ctl_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (~v) + 64'd1 : v;
	endfunction

	function automatic logic [63:0] to_sgn(input logic neg, input logic [63:0] m);
		if (neg)
			to_sgn = m[63] ? 64'h8000_0000_0000_0000 : (~m) + 64'd1;
		else
			to_sgn = m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			sat_add = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		else
			sat_add = s[63:0];
	endfunction

endpackage

### rtl/gpne_mul.sv
// ----------------------------------------------------------------------------
// gpne_mul
// 64x64 unsigned multiply over four 32x32 partial products, shifted and saturated
// ----------------------------------------------------------------------------
module gpne_mul import gpne_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mul_ctl_t    ctl,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        busy,
	output logic        done,
	output logic [63:0] res
);

	logic [63:0]  a_q, b_q;
	shift_t       sh_q;
	logic [2:0]   k_q;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [127:0] acc_q;
	logic [31:0]  op_a, op_b;
	logic [127:0] pp_ext, shifted;

	always_comb begin
		case (k_q[1:0])
			2'd0: begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
			2'd1: begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
			2'd2: begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
			default: begin op_a = a_q[63:32]; op_b = b_q[63:32]; end
		endcase
		case (k_q)
			3'd1: pp_ext = {64'd0, pp_s1};
			3'd2, 3'd3: pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
		case (sh_q)
			SH_0: shifted = acc_q;
			SH_16: shifted = acc_q >> 16;
			SH_24: shifted = acc_q >> 24;
			default: shifted = acc_q >> 32;
		endcase
		res = (shifted[127:64] != 64'd0) ? '1 : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				k_q <= 3'd0;
			end else if (busy_q) begin
				if (k_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= a;
			b_q <= b;
			sh_q <= ctl.sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (k_q != 3'd4)
				pp_s1 <= 64'(op_a) * 64'(op_b);
			if (k_q != 3'd0)
				acc_q <= acc_q + pp_ext;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

### rtl/gpne_divsqrt.sv
// ----------------------------------------------------------------------------
// gpne_divsqrt
// restoring divider (one quotient bit a cycle) and square root (one root bit a cycle from two radicand bits)
// ----------------------------------------------------------------------------
module gpne_divsqrt import gpne_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ds_ctl_t     ctl,
	input  logic [64:0] dividend,
	input  logic [63:0] divisor,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [63:0] res
);

	logic [95:0] n_q;
	logic [63:0] rem_q, d_q;
	logic [64:0] q_q;
	logic        sqrt_q, busy_q, done_q;
	logic [6:0]  cnt_q;
	logic [65:0] cand, sub;
	logic        ge;

	always_comb begin
		if (sqrt_q) begin
			cand = {rem_q, n_q[95:94]};
			sub = {16'd0, q_q[47:0], 2'b01};
		end else begin
			cand = {1'b0, rem_q, n_q[95]};
			sub = {2'b00, d_q};
		end
		ge = (cand >= sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.sqrt ? 7'd48 : 7'd65;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			sqrt_q <= ctl.sqrt;
			n_q <= ctl.sqrt ? {radicand, 32'd0} : {dividend, 31'd0};
			d_q <= divisor;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(cand - sub) : cand[63:0];
			q_q <= {q_q[63:0], ge};
			n_q <= sqrt_q ? {n_q[93:0], 2'b00} : {n_q[94:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res = q_q[63:0];

endmodule

### rtl/group_pair_nonbonded_energy.sv
// ----------------------------------------------------------------------------
// group_pair_nonbonded_energy
// coulomb and lennard-jones pair energies summed over a group pair, with
// floors on r squared and a linear cutoff switch applied on the last pair
//
// channel | signals                           | direction
// in      | in_valid / in_ready + pair fields | request in
// out     | out_valid / out_ready + energies  | request out, last pair only
// cfg     | cfg_we, cfg_index, cfg_data       | register write, no wait
//
// when both floors give a real divide, a pair runs multiply steps on the shared
// 32x32 multiplier, two divides and a square root; a last pair adds the switch
// divide, final scaling and the emit state
// in_ready is high only while the sequencer is idle
// a finished result waits in the output register; the next request is taken
// meanwhile and the sequencer stalls only at its own result if it is still held
// arst_n clears sequencer, sums, output valid and registers to defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module group_pair_nonbonded_energy import gpne_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   disp_x,
	input  logic signed [31:0]   disp_y,
	input  logic signed [31:0]   disp_z,
	input  logic signed [15:0]   charge_first,
	input  logic signed [15:0]   charge_second,
	input  logic [47:0]          repulsion_coef,
	input  logic [47:0]          dispersion_coef,
	input  logic [31:0]          center_dist_sq,
	input  logic                 scaled_group,
	input  logic                 last_pair,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [63:0]   coulomb_energy,
	output logic signed [63:0]   lj_energy,
	output logic                 within_cutoff,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EMIT} state_t;
	typedef enum logic [4:0] {
		P_DX, P_DY, P_DZ, P_RL, P_S4, P_S6, P_SIG, P_AS, P_P, P_Q,
		P_RQ, P_SQRT, P_QQ, P_CQ, P_SW, P_CS, P_ES, P_CW, P_EW
	} step_t;
	typedef enum logic [1:0] {K_NONE, K_MUL, K_DIV, K_SQRT} kind_t;

	state_t state_q;
	step_t  step_q;

	logic [31:0] cut_q, start_q, ljf_q, cqf_q, cs_q, eps_q, sig_q;

	logic [31:0] dxm_q, dym_q, dzm_q, d2_q;
	logic [15:0] qim_q, qjm_q;
	logic        qneg_q, scaled_q, last_q;
	logic [47:0] a_q, b_q;

	logic [63:0] r2_q, s2_q, t_q, s6_q, p_q, fq_q, sw_q, ec_q, el_q;
	logic [63:0] csum_q, lsum_q;
	logic        out_valid_q, within_q;
	logic [63:0] out_c_q, out_l_q;

	kind_t       kind;
	logic [63:0] ma, mb, rl2, rq2, lj_floor, cq_floor, res, pair;
	shift_t      msh;
	logic [64:0] dvd;
	logic [63:0] dvs;
	logic        inrange, wb_fire;
	mul_ctl_t    mul_ctl;
	ds_ctl_t     ds_ctl;
	logic        mul_busy, mul_done, ds_busy, ds_done;
	logic [63:0] mul_res, ds_res;

	assign lj_floor = {16'd0, ljf_q, 16'd0};
	assign cq_floor = {16'd0, cqf_q, 16'd0};
	assign rl2 = (r2_q < lj_floor) ? lj_floor : r2_q;
	assign rq2 = (r2_q < cq_floor) ? cq_floor : r2_q;
	assign inrange = (d2_q < cut_q);

	// operation of the current step
	always_comb begin
		kind = K_MUL;
		ma = '0;
		mb = '0;
		msh = SH_32;
		dvd = {1'b1, 64'd0};
		dvs = rl2;
		case (step_q)
			P_DX: begin ma = {32'd0, dxm_q}; mb = {32'd0, dxm_q}; msh = SH_0; end
			P_DY: begin ma = {32'd0, dym_q}; mb = {32'd0, dym_q}; msh = SH_0; end
			P_DZ: begin ma = {32'd0, dzm_q}; mb = {32'd0, dzm_q}; msh = SH_0; end
			P_RL: kind = (rl2 <= 64'd1) ? K_NONE : K_DIV;
			P_S4: begin ma = s2_q; mb = s2_q; end
			P_S6: begin ma = t_q; mb = s2_q; end
			P_SIG: begin
				kind = scaled_q ? K_MUL : K_NONE;
				ma = s6_q;
				mb = {16'd0, sig_q, 16'd0};
			end
			P_AS: begin ma = {a_q, 16'd0}; mb = s6_q; end
			P_P: begin ma = t_q; mb = s6_q; end
			P_Q: begin ma = {b_q, 16'd0}; mb = s6_q; end
			P_RQ: begin
				kind = (rq2 <= 64'd1) ? K_NONE : K_DIV;
				dvs = rq2;
			end
			P_SQRT: kind = K_SQRT;
			P_QQ: begin ma = {48'd0, qim_q}; mb = {48'd0, qjm_q}; msh = SH_0; end
			P_CQ: begin ma = t_q; mb = fq_q; msh = SH_24; end
			P_SW: begin
				kind = (inrange && d2_q > start_q) ? K_DIV : K_NONE;
				dvd = {1'b0, 32'(cut_q - d2_q), 32'd0};
				dvs = {32'd0, 32'(cut_q - start_q)};
			end
			P_CS: begin
				kind = scaled_q ? K_MUL : K_NONE;
				ma = mag64(csum_q);
				mb = mag64({{32{cs_q[31]}}, cs_q});
				msh = SH_16;
			end
			P_ES: begin
				kind = scaled_q ? K_MUL : K_NONE;
				ma = mag64(lsum_q);
				mb = {32'd0, eps_q};
				msh = SH_16;
			end
			P_CW: begin ma = mag64(ec_q); mb = sw_q; end
			P_EW: begin ma = mag64(el_q); mb = sw_q; end
			default: kind = K_NONE;
		endcase
	end

	always_comb begin
		case (kind)
			K_MUL: res = mul_res;
			K_DIV, K_SQRT: res = ds_res;
			default: res = (step_q == P_SW) ? 64'h0000_0001_0000_0000 : '1;
		endcase
		pair = (p_q >= res) ? to_sgn(1'b0, p_q - res) : to_sgn(1'b1, res - p_q);
		wb_fire = (state_q == S_ISSUE && kind == K_NONE) ||
			(state_q == S_WAIT && (mul_done || ds_done));
		mul_ctl.start = (state_q == S_ISSUE) && (kind == K_MUL);
		mul_ctl.sh = msh;
		ds_ctl.start = (state_q == S_ISSUE) && (kind == K_DIV || kind == K_SQRT);
		ds_ctl.sqrt = (kind == K_SQRT);
	end

	gpne_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (ma),
		.b      (mb),
		.busy   (mul_busy),
		.done   (mul_done),
		.res    (mul_res)
	);

	gpne_divsqrt u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ds_ctl),
		.dividend (dvd),
		.divisor  (dvs),
		.radicand (t_q),
		.busy     (ds_busy),
		.done     (ds_done),
		.res      (ds_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= RST_CUTOFF_SQ;
			start_q <= RST_SWITCH_START_SQ;
			ljf_q <= RST_LJ_FLOOR_SQ;
			cqf_q <= RST_COULOMB_FLOOR_SQ;
			cs_q <= RST_CHARGE_SCALE;
			eps_q <= RST_EPSILON_SCALE;
			sig_q <= RST_SIGMA_SCALE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CUTOFF_SQ: cut_q <= cfg_data;
				CFG_SWITCH_START_SQ: start_q <= cfg_data;
				CFG_LJ_FLOOR_SQ: ljf_q <= cfg_data;
				CFG_COULOMB_FLOOR_SQ: cqf_q <= cfg_data;
				CFG_CHARGE_SCALE: cs_q <= cfg_data;
				CFG_EPSILON_SCALE: eps_q <= cfg_data;
				CFG_SIGMA_SCALE: sig_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture and step results
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dxm_q <= 32'(mag64(64'(disp_x)));
			dym_q <= 32'(mag64(64'(disp_y)));
			dzm_q <= 32'(mag64(64'(disp_z)));
			qim_q <= charge_first[15] ? 16'(-charge_first) : charge_first;
			qjm_q <= charge_second[15] ? 16'(-charge_second) : charge_second;
			qneg_q <= charge_first[15] ^ charge_second[15];
			a_q <= repulsion_coef;
			b_q <= dispersion_coef;
			d2_q <= center_dist_sq;
			scaled_q <= scaled_group;
			last_q <= last_pair;
		end
		if (wb_fire) begin
			case (step_q)
				P_DX: r2_q <= res;
				P_DY, P_DZ: r2_q <= r2_q + res;
				P_RL: s2_q <= res;
				P_S4, P_AS, P_RQ, P_QQ: t_q <= res;
				P_S6: s6_q <= res;
				P_SIG: if (kind != K_NONE) s6_q <= res;
				P_P: p_q <= res;
				P_SQRT: fq_q <= res;
				P_SW: sw_q <= res;
				P_CS: ec_q <= (kind == K_NONE) ? csum_q :
					to_sgn(csum_q[63] ^ cs_q[31], res);
				P_ES: el_q <= (kind == K_NONE) ? lsum_q : to_sgn(lsum_q[63], res);
				P_CW: ec_q <= to_sgn(ec_q[63], res);
				P_EW: el_q <= to_sgn(el_q[63], res);
				default: ;
			endcase
		end
	end

	// sequencer, sums and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= P_DX;
			csum_q <= '0;
			lsum_q <= '0;
			out_valid_q <= 1'b0;
			within_q <= 1'b0;
			out_c_q <= '0;
			out_l_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q <= P_DX;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE, S_WAIT: begin
					if (state_q == S_ISSUE && kind != K_NONE)
						state_q <= S_WAIT;
					if (wb_fire) begin
						if (step_q == P_Q)
							lsum_q <= sat_add(lsum_q, pair);
						if (step_q == P_CQ)
							csum_q <= sat_add(csum_q, to_sgn(qneg_q, res));
						if (step_q == P_CQ && !last_q)
							state_q <= S_IDLE;
						else if ((step_q == P_SW && !inrange) || step_q == P_EW)
							state_q <= S_EMIT;
						else begin
							step_q <= step_t'(step_q + 5'd1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						within_q <= inrange;
						out_c_q <= inrange ? ec_q : 64'd0;
						out_l_q <= inrange ? el_q : 64'd0;
						csum_q <= '0;
						lsum_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign coulomb_energy = out_c_q;
	assign lj_energy = out_l_q;
	assign within_cutoff = within_q;

	`ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
	`ASSERT_NOW(a_one_unit, !(mul_busy && ds_busy))
	`ASSERT_NOW(a_done_in_wait, !(mul_done || ds_done) || state_q == S_WAIT)
	`ASSERT_NOW(a_zero_outside, !(out_valid && !within_cutoff) || (coulomb_energy == '0 && lj_energy == '0))

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: group pair nonbonded energy testbench
// drives atom pair requests through valid/ready, predicts the group energies
// in fixed point and compares every group result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import gpne_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int GROUP_LAT = 400;
	localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] dx, dy, dz;
		logic signed [15:0] qa, qb;
		logic [47:0] rep, disp;
		logic [31:0] d2;
		logic scaled, last;
	} pair_t;

	typedef struct packed {
		logic [63:0] coul, lj;
		logic in_cut;
	} energy_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [31:0] disp_x = 0, disp_y = 0, disp_z = 0;
	logic signed [15:0] charge_first = 0, charge_second = 0;
	logic [47:0] repulsion_coef = 0, dispersion_coef = 0;
	logic [31:0] center_dist_sq = 0;
	logic scaled_group = 0, last_pair = 0;
	logic signed [63:0] coulomb_energy, lj_energy;
	logic within_cutoff;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CUTOFF_SQ;
	logic [CFG_W-1:0] cfg_data = 0;

	logic [63:0] m_cut, m_start, m_ljf, m_qf, m_eps, m_sig;
	logic signed [63:0] m_cs;
	logic [63:0] coul_acc, lj_acc;
	energy_t energy_q[$];
	int errors = 0, cycles = 0, hold_off = 0;

	group_pair_nonbonded_energy uut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] umul_sh(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = a * b;
		p = p >> sh;
		return (p[127:64] != 0) ? U64_MAX : p[63:0];
	endfunction

	function automatic logic [63:0] mag_of(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic logic [63:0] signed_of(logic neg, logic [63:0] m);
		if (neg) return m >= S64_MIN ? S64_MIN : -m;
		return m > S64_MAX ? S64_MAX : m;
	endfunction

	function automatic logic [63:0] smul_sh(logic [63:0] a, logic [63:0] b, int sh);
		return signed_of(a[63] ^ b[63], umul_sh(mag_of(a), mag_of(b), sh));
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] inv_q32(logic [63:0] r);
		logic [64:0] one;
		logic [64:0] q;
		one = 65'd1 << 64;
		if (r <= 1) return U64_MAX;
		q = one / r;
		return q[63:0];
	endfunction

	function automatic logic [63:0] root_q32(logic [63:0] x);
		logic [95:0] t;
		logic [63:0] y, c;
		logic [127:0] sq;
		t = {x, 32'd0};
		y = 0;
		for (int b = 47; b >= 0; b--) begin
			c = y | (64'd1 << b);
			sq = c * c;
			if (sq <= {32'd0, t}) y = c;
		end
		return y;
	endfunction

	task automatic energy_step(input pair_t p);
		logic [63:0] ax, ay, az, r2, rl, rq, s2, s6, pa, pb, fq, lp, qq, ec, el, sw;
		logic [127:0] num;
		energy_t e;
		ax = mag_of({{32{p.dx[31]}}, p.dx});
		ay = mag_of({{32{p.dy[31]}}, p.dy});
		az = mag_of({{32{p.dz[31]}}, p.dz});
		r2 = ax * ax + ay * ay + az * az;
		rl = r2 < (m_ljf << 16) ? m_ljf << 16 : r2;
		rq = r2 < (m_qf << 16) ? m_qf << 16 : r2;
		s2 = inv_q32(rl);
		s6 = umul_sh(umul_sh(s2, s2, 32), s2, 32);
		if (p.scaled) s6 = umul_sh(s6, m_sig << 16, 32);
		pa = umul_sh(umul_sh({p.rep, 16'd0}, s6, 32), s6, 32);
		pb = umul_sh({p.disp, 16'd0}, s6, 32);
		lp = pa >= pb ? signed_of(0, pa - pb) : signed_of(1, pb - pa);
		lj_acc = add_sat(lj_acc, lp);
		fq = root_q32(inv_q32(rq));
		qq = $signed(p.qa) * $signed(p.qb);
		coul_acc = add_sat(coul_acc, signed_of(qq[63], umul_sh(mag_of(qq), fq, 24)));
		if (!p.last) return;
		e = '0;
		if (p.d2 < m_cut) begin
			ec = coul_acc;
			el = lj_acc;
			if (p.d2 > m_start) begin
				num = (m_cut - p.d2) << 32;
				num = num / (m_cut - m_start);
				sw = num[63:0];
			end else begin
				sw = 64'd1 << 32;
			end
			if (p.scaled) begin
				ec = smul_sh(ec, m_cs, 16);
				el = smul_sh(el, m_eps, 16);
			end
			e.coul = smul_sh(ec, sw, 32);
			e.lj = smul_sh(el, sw, 32);
			e.in_cut = 1;
		end
		energy_q.push_back(e);
		coul_acc = 0;
		lj_acc = 0;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// receiver
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 0;
			hold_off <= hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 15) ? 0 : 1;
		end
	end

	always @(posedge clk) begin
		energy_t w;
		if (arst_n && out_valid && out_ready) begin
			if (energy_q.size() == 0) begin
				report("unexpected result", coulomb_energy, 0);
			end else begin
				w = energy_q.pop_front();
				if (coulomb_energy !== w.coul) report("coulomb_energy", coulomb_energy, w.coul);
				if (lj_energy !== w.lj) report("lj_energy", lj_energy, w.lj);
				if (within_cutoff !== w.in_cut) report("within_cutoff", within_cutoff, w.in_cut);
			end
		end
	end

	task automatic send_pair(input pair_t p);
		int n;
		energy_step(p);
		disp_x <= p.dx;
		disp_y <= p.dy;
		disp_z <= p.dz;
		charge_first <= p.qa;
		charge_second <= p.qb;
		repulsion_coef <= p.rep;
		dispersion_coef <= p.disp;
		center_dist_sq <= p.d2;
		scaled_group <= p.scaled;
		last_pair <= p.last;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		n = gap_len();
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_CUTOFF_SQ: m_cut = v;
			CFG_SWITCH_START_SQ: m_start = v;
			CFG_LJ_FLOOR_SQ: m_ljf = v;
			CFG_COULOMB_FLOOR_SQ: m_qf = v;
			CFG_CHARGE_SCALE: m_cs = {{32{v[31]}}, v};
			CFG_EPSILON_SCALE: m_eps = v;
			default: m_sig = v;
		endcase
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (energy_q.size() != 0) @(negedge clk);
		repeat (GROUP_LAT) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_disp();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 0;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
		endcase
	endfunction

	function automatic logic [47:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return 48'({$urandom, $urandom});
			1: return 0;
			default: return $urandom_range(0, 32'h00FF_FFFF);
		endcase
	endfunction

	function automatic pair_t rand_pair(input logic last, input logic [31:0] d2,
		input logic scaled);
		pair_t p;
		p.dx = rand_disp();
		p.dy = rand_disp();
		p.dz = rand_disp();
		p.qa = 16'($urandom);
		p.qb = 16'($urandom);
		p.rep = rand_coef();
		p.disp = rand_coef();
		p.d2 = d2;
		p.scaled = scaled;
		p.last = last;
		return p;
	endfunction

	function automatic logic [31:0] rand_d2();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return m_cut;
			2: return m_start;
			default: return $urandom_range(0, m_cut > 32'h1000_0000 ? 32'h1000_0000 : m_cut + 100);
		endcase
	endfunction

	task automatic run_groups(input int n);
		int len;
		logic [31:0] d2;
		logic sc;
		for (int g = 0; g < n; g++) begin
			len = $urandom_range(1, 6);
			d2 = rand_d2();
			sc = $urandom_range(0, 1);
			for (int i = 0; i < len; i++)
				send_pair(rand_pair(i == len - 1, d2, $urandom_range(0, 3) == 0 ? ~sc : sc));
		end
	endtask

	task automatic test_directed();
		pair_t p;
		p = '0;
		p.last = 1;
		send_pair(p);
		p.qa = 16'h7FFF;
		p.qb = 16'h8000;
		p.rep = '1;
		p.disp = '1;
		p.dx = 32'h8000_0000;
		p.dy = 32'h7FFF_FFFF;
		p.dz = 32'hFFFF_FFFF;
		p.scaled = 1;
		send_pair(p);
		p.dx = 32'h0001_0000;
		p.dy = 0;
		p.dz = 0;
		p.qa = 16'h1000;
		p.qb = 16'h1000;
		p.rep = 48'h1_0000;
		p.disp = 48'h2_0000;
		p.last = 0;
		send_pair(p);
		p.last = 1;
		p.d2 = 32'(m_start + 1000);
		send_pair(p);
		p.d2 = 32'(m_cut);
		send_pair(p);
		p.d2 = '1;
		send_pair(p);
		p.d2 = 32'(m_start);
		p.scaled = 0;
		send_pair(p);
		drain();
		write_reg(CFG_LJ_FLOOR_SQ, 0);
		write_reg(CFG_COULOMB_FLOOR_SQ, 0);
		write_reg(CFG_SWITCH_START_SQ, '1);
		p = '0;
		p.qa = 16'h7FFF;
		p.qb = 16'h7FFF;
		p.rep = 48'h10;
		p.last = 1;
		send_pair(p);
		p.d2 = 32'h0010_0000;
		send_pair(p);
		drain();
	endtask

	task automatic test_settings();
		write_reg(CFG_CUTOFF_SQ, '1);
		write_reg(CFG_SWITCH_START_SQ, 0);
		write_reg(CFG_LJ_FLOOR_SQ, '1);
		write_reg(CFG_COULOMB_FLOOR_SQ, '1);
		write_reg(CFG_CHARGE_SCALE, 32'h8000_0000);
		write_reg(CFG_EPSILON_SCALE, '1);
		write_reg(CFG_SIGMA_SCALE, '1);
		run_groups(30);
		drain();
		write_reg(CFG_CUTOFF_SQ, 0);
		write_reg(CFG_CHARGE_SCALE, 32'h7FFF_FFFF);
		write_reg(CFG_EPSILON_SCALE, 0);
		write_reg(CFG_SIGMA_SCALE, 0);
		run_groups(10);
		drain();
		for (int k = 0; k < 4; k++) begin
			write_reg(CFG_CUTOFF_SQ, $urandom_range(1 << 16, 200 << 16));
			write_reg(CFG_SWITCH_START_SQ, $urandom_range(0, m_cut + 100));
			write_reg(CFG_LJ_FLOOR_SQ, $urandom_range(0, 1 << 16));
			write_reg(CFG_COULOMB_FLOOR_SQ, $urandom_range(0, 1 << 16));
			write_reg(CFG_CHARGE_SCALE, $urandom);
			write_reg(CFG_EPSILON_SCALE, $urandom_range(0, 4 << 16));
			write_reg(CFG_SIGMA_SCALE, $urandom_range(0, 4 << 16));
			run_groups(40);
			drain();
		end
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_off <= 3000;
		run_groups(12);
		drain();
	endtask

	initial begin
		m_cut = RST_CUTOFF_SQ;
		m_start = RST_SWITCH_START_SQ;
		m_ljf = RST_LJ_FLOOR_SQ;
		m_qf = RST_COULOMB_FLOOR_SQ;
		m_cs = RST_CHARGE_SCALE;
		m_eps = RST_EPSILON_SCALE;
		m_sig = RST_SIGMA_SCALE;
		coul_acc = 0;
		lj_acc = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_settings();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
